// ===== rtl/hsl2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSL to RGB package
// Pixel types, fixed-point widths and the per-channel hue segment helpers.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

	localparam int HUE_W    = 11;
	localparam int CHAN_W   = 9;
	localparam int FAC_W    = 9;
	localparam int QP_W     = 13;
	localparam int DIFF_W   = 14;
	localparam int PROD_W   = 24;
	localparam int SUM_W    = 16;
	localparam int T_W      = 13;

	localparam logic signed [T_W-1:0] HUE_SIXTH = T_W'(256);
	localparam logic signed [T_W-1:0] HUE_FULL  = T_W'(1536);
	localparam logic [CHAN_W-1:0]     ONE_FIX   = CHAN_W'(256);
	localparam logic [CHAN_W-1:0]     HALF_FIX  = CHAN_W'(128);

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [CHAN_W-1:0] saturation;
		logic [CHAN_W-1:0] lightness;
	} hsl_pixel_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_pixel_t;

	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_HIGH,
		SEG_FALL,
		SEG_LOW
	} seg_code_t;

	typedef struct packed {
		seg_code_t        code;
		logic [FAC_W-1:0] fac;
	} seg_t;

	// Wraps a shifted hue into 0..6 sixths and picks the ramp segment and its weight.
	function automatic seg_t hue_segment(logic signed [T_W-1:0] t);
		logic signed [T_W-1:0] tw;
		logic signed [T_W-1:0] down;
		seg_t r;
		if (t < 0) begin
			tw = t + HUE_FULL;
		end else if (t > HUE_FULL) begin
			tw = t - HUE_FULL;
		end else begin
			tw = t;
		end
		down = (HUE_SIXTH <<< 2) - tw;
		r.fac = '0;
		if (tw < HUE_SIXTH) begin
			r.code = SEG_RISE;
			r.fac  = tw[FAC_W-1:0];
		end else if (tw < HUE_SIXTH * 3) begin
			r.code = SEG_HIGH;
		end else if (tw < (HUE_SIXTH <<< 2)) begin
			r.code = SEG_FALL;
			r.fac  = down[FAC_W-1:0];
		end else begin
			r.code = SEG_LOW;
		end
		return r;
	endfunction

	function automatic logic [CHAN_W-1:0] clamp_chan(logic signed [SUM_W-1:0] v);
		logic [CHAN_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > SUM_W'(ONE_FIX)) begin
			r = ONE_FIX;
		end else begin
			r = v[CHAN_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/hsl_to_rgb_pixel.sv =====
// ----------------------------------------------------------------------------
// HSL to RGB pixel converter
// Four-stage pipeline converting fixed-point HSL pixels to clamped RGB pixels.
// ----------------------------------------------------------------------------
// The converter takes one pixel per clock while the output is not stalled;
// each accepted beat passes through the stage 1 to stage 4 registers in turn
// before it appears on the output. The first stage forms lightness times
// saturation and the hue segment of each channel, the second forms q, p and
// their difference, the third multiplies that difference by each channel's
// ramp weight, and the fourth adds p, clamps and holds the output beat. Every
// stage carries a valid bit and loads whenever it is empty or its successor
// moves, so bubbles close up and a stalled output loses or repeats nothing.
module hsl_to_rgb_pixel (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  hsl2rgb_pkg::hsl_pixel_t in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output hsl2rgb_pkg::rgb_pixel_t out_data
);
	import hsl2rgb_pkg::*;

	logic en_s1, en_s2, en_s3, en_s4;
	logic v_s1, v_s2, v_s3, v_s4;

	// Stage 1 registers.
	logic [2*CHAN_W-1:0] ls_s1;
	logic [CHAN_W-1:0]   l_s1, s_s1;
	logic                gray_s1, black_s1, low_s1;
	seg_t                seg_s1 [3];

	// Stage 2 registers.
	logic signed [QP_W-1:0]   q_s2, p_s2;
	logic signed [DIFF_W-1:0] diff_s2;
	logic [CHAN_W-1:0]        l_s2;
	logic                     gray_s2, black_s2;
	seg_t                     seg_s2 [3];

	// Stage 3 registers.
	logic signed [QP_W-1:0]   q_s3, p_s3;
	logic signed [PROD_W-1:0] prod_s3 [3];
	logic [CHAN_W-1:0]        l_s3;
	logic                     gray_s3, black_s3;
	seg_code_t                code_s3 [3];

	// Stage 4 (output) register.
	rgb_pixel_t out_s4;

	logic signed [T_W-1:0]    t_in [3];
	logic [2*CHAN_W-1:0]      ls_in;
	logic signed [QP_W-1:0]   l_x, s_x, half_ls, q_c, p_c;
	logic [CHAN_W-1:0]        chan_c [3];
	logic [CHAN_W-1:0]        gray_c;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign t_in[0] = $signed({2'b00, in_data.hue}) + (HUE_SIXTH <<< 1);
	assign t_in[1] = $signed({2'b00, in_data.hue});
	assign t_in[2] = $signed({2'b00, in_data.hue}) - (HUE_SIXTH <<< 1);
	assign ls_in   = in_data.lightness * in_data.saturation;

	assign l_x     = $signed(QP_W'(l_s1));
	assign s_x     = $signed(QP_W'(s_s1));
	assign half_ls = $signed(QP_W'(ls_s1[2*CHAN_W-1:8]));
	assign q_c     = low_s1 ? (l_x + half_ls) : (l_x + s_x - half_ls);
	assign p_c     = (l_x <<< 1) - q_c;

	always_comb begin
		logic signed [SUM_W-1:0] p_ext, q_ext, sum;
		p_ext  = SUM_W'(p_s3);
		q_ext  = SUM_W'(q_s3);
		gray_c = (l_s3 > ONE_FIX) ? ONE_FIX : l_s3;
		for (int c = 0; c < 3; c++) begin
			sum = p_ext + SUM_W'(prod_s3[c][PROD_W-1:8]);
			unique case (code_s3[c])
				SEG_RISE, SEG_FALL: chan_c[c] = clamp_chan(sum);
				SEG_HIGH:           chan_c[c] = clamp_chan(q_ext);
				default:            chan_c[c] = clamp_chan(p_ext);
			endcase
			if (gray_s3) begin
				chan_c[c] = gray_c;
			end else if (black_s3) begin
				chan_c[c] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ls_s1    <= ls_in;
			l_s1     <= in_data.lightness;
			s_s1     <= in_data.saturation;
			gray_s1  <= (in_data.saturation == '0);
			black_s1 <= (in_data.lightness == '0);
			low_s1   <= (in_data.lightness < HALF_FIX);
			for (int c = 0; c < 3; c++) begin
				seg_s1[c] <= hue_segment(t_in[c]);
			end
		end
		if (en_s2) begin
			q_s2     <= q_c;
			p_s2     <= p_c;
			diff_s2  <= DIFF_W'(q_c) - DIFF_W'(p_c);
			l_s2     <= l_s1;
			gray_s2  <= gray_s1;
			black_s2 <= black_s1;
			seg_s2   <= seg_s1;
		end
		if (en_s3) begin
			q_s3     <= q_s2;
			p_s3     <= p_s2;
			l_s3     <= l_s2;
			gray_s3  <= gray_s2;
			black_s3 <= black_s2;
			for (int c = 0; c < 3; c++) begin
				prod_s3[c] <= PROD_W'(diff_s2) * PROD_W'($signed({1'b0, seg_s2[c].fac}));
				code_s3[c] <= seg_s2[c].code;
			end
		end
		if (en_s4) begin
			out_s4.red   <= chan_c[0];
			out_s4.green <= chan_c[1];
			out_s4.blue  <= chan_c[2];
		end
	end

	assign out_valid = v_s4;
	assign out_data  = out_s4;

endmodule

// ===== rtl/hsl2rgb_checker.sv =====
// ----------------------------------------------------------------------------
// HSL to RGB port checker
// Watches the converter's ports for handshake and range violations.
// ----------------------------------------------------------------------------
module hsl2rgb_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input hsl2rgb_pkg::hsl_pixel_t in_data,
	input logic                    out_valid,
	input logic                    out_ready,
	input hsl2rgb_pkg::rgb_pixel_t out_data
);
	import hsl2rgb_pkg::*;

	// A stalled output beat stays valid.
	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	// A stalled output beat keeps its payload.
	a_out_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("output payload changed while stalled");

	// An empty output stage means the pipeline can take a new beat.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output stage");

	// Every channel is clamped to 1.0.
	a_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.red <= ONE_FIX) && (out_data.green <= ONE_FIX)
			&& (out_data.blue <= ONE_FIX))
		else $error("output channel above 1.0");

endmodule

bind hsl_to_rgb_pixel hsl2rgb_checker u_hsl2rgb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
